@@ hdl/u8d_pkg.sv @@
`timescale 1ns / 1ps
// u8d_pkg: shared types, constants and the script classifier of the utf-8 decoder
// no dependencies

package u8d_pkg;

  localparam int unsigned CpWidth  = 21;
  localparam int unsigned LenWidth = 3;
  localparam int unsigned RemWidth = 2;

  // lead byte thresholds
  localparam logic [7:0] LeadTwo    = 8'h80;
  localparam logic [7:0] LeadThree  = 8'hE0;
  localparam logic [7:0] LeadFour   = 8'hF0;
  localparam logic [7:0] LeadBad    = 8'hF8;

  localparam logic [7:0] MaskTwo    = 8'h1F;
  localparam logic [7:0] MaskThree  = 8'h0F;
  localparam logic [7:0] MaskFour   = 8'h07;
  localparam logic [7:0] MaskCont   = 8'h3F;

  localparam logic [CpWidth-1:0] CpReplacement = 21'h00FFFD;

  typedef enum logic [3:0] {
    CLS_COMMON = 4'd0,
    CLS_LATIN  = 4'd1,
    CLS_GRK    = 4'd2,
    CLS_CYR    = 4'd3,
    CLS_HEB    = 4'd4,
    CLS_ARAB   = 4'd5,
    CLS_DEVA   = 4'd6,
    CLS_HIRA   = 4'd7,
    CLS_KATA   = 4'd8,
    CLS_CJK    = 4'd9,
    CLS_KOREAN = 4'd10,
    CLS_SMILEY = 4'd11
  } script_e;

  typedef struct packed {
    logic [CpWidth-1:0]  partial;
    logic [RemWidth-1:0] remaining;
    logic [LenWidth-1:0] cur_len;
  } seq_state_t;

  typedef struct packed {
    logic [CpWidth-1:0]  code_point;
    logic [LenWidth-1:0] seq_length;
    script_e             script_class;
    logic                bad_lead;
    logic                end_of_string;
  } char_res_t;

  function automatic script_e script_of(input logic [CpWidth-1:0] cp);
    script_e s;
    s = CLS_COMMON;
    if (cp < 21'h80) s = CLS_LATIN;
    else if (cp >= 21'h0370 && cp < 21'h0400) s = CLS_GRK;
    else if (cp >= 21'h0400 && cp < 21'h0530) s = CLS_CYR;
    else if (cp >= 21'h0590 && cp < 21'h0600) s = CLS_HEB;
    else if (cp >= 21'h0600 && cp < 21'h0700) s = CLS_ARAB;
    else if (cp >= 21'h3040 && cp < 21'h30A0) s = CLS_HIRA;
    else if (cp >= 21'h30A0 && cp < 21'h3100) s = CLS_KATA;
    else if (cp >= 21'h4E00 && cp < 21'hA000) s = CLS_CJK;
    else if (cp >= 21'hAC00 && cp < 21'hD7B0) s = CLS_KOREAN;
    else if (cp >= 21'h1F600 && cp < 21'h1F650) s = CLS_SMILEY;
    return s;
  endfunction

endpackage

@@ hdl/u8d_if.sv @@
`timescale 1ns / 1ps
// u8d_in_if / u8d_out_if: valid/ready channels of the utf-8 decoder
// no dependencies

interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8d_out_if #(
  parameter int unsigned COUNT_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [20:0]            code_point;
  logic [2:0]             seq_length;
  logic [3:0]             script_class;
  logic                   bad_lead;
  logic                   end_of_string;
  logic [COUNT_WIDTH-1:0] char_count;

  modport source (output valid, output code_point, output seq_length, output script_class,
                  output bad_lead, output end_of_string, output char_count, input ready);
  modport sink   (input valid, input code_point, input seq_length, input script_class,
                  input bad_lead, input end_of_string, input char_count, output ready);
endinterface

@@ hdl/u8d_decode.sv @@
`timescale 1ns / 1ps
// u8d_decode: per-byte decode step, next sequence state, counter and result
// depends on u8d_pkg

module u8d_decode #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic [7:0]             byte_i,
  input  u8d_pkg::seq_state_t    state_i,
  input  logic [COUNT_WIDTH-1:0] count_i,
  output u8d_pkg::seq_state_t    state_o,
  output logic [COUNT_WIDTH-1:0] count_o,
  output logic                   res_valid_o,
  output u8d_pkg::char_res_t     res_o,
  output logic [COUNT_WIDTH-1:0] res_count_o
);
  import u8d_pkg::*;

  logic [COUNT_WIDTH-1:0] count_inc;
  logic [CpWidth-1:0]     shifted;
  logic [RemWidth-1:0]    rem_dec;

  // saturating increment
  assign count_inc = (count_i == {COUNT_WIDTH{1'b1}}) ? count_i
                                                      : count_i + COUNT_WIDTH'(1);
  assign shifted   = {state_i.partial[CpWidth-7:0], byte_i[5:0]};
  assign rem_dec   = state_i.remaining - RemWidth'(1);

  always_comb begin
    state_o                = state_i;
    count_o                = count_i;
    res_valid_o            = 1'b0;
    res_o.code_point       = '0;
    res_o.seq_length       = LenWidth'(1);
    res_o.script_class     = CLS_COMMON;
    res_o.bad_lead         = 1'b0;
    res_o.end_of_string    = 1'b0;
    res_count_o            = count_inc;

    if (state_i.remaining != '0) begin
      // continuation byte, not checked
      state_o.partial   = shifted;
      state_o.remaining = rem_dec;
      if (rem_dec == '0) begin
        res_valid_o        = 1'b1;
        res_o.code_point   = shifted;
        res_o.seq_length   = state_i.cur_len;
        res_o.script_class = script_of(shifted);
        count_o            = count_inc;
      end
    end else if (byte_i == 8'h00) begin
      // terminator reports the total and clears it
      res_valid_o         = 1'b1;
      res_o.end_of_string = 1'b1;
      res_count_o         = count_i;
      count_o             = '0;
    end else if (byte_i < LeadTwo) begin
      state_o.cur_len    = LenWidth'(1);
      res_valid_o        = 1'b1;
      res_o.code_point   = CpWidth'(byte_i);
      res_o.script_class = script_of(CpWidth'(byte_i));
      count_o            = count_inc;
    end else if (byte_i < LeadThree) begin
      state_o.partial   = CpWidth'(byte_i & MaskTwo);
      state_o.remaining = RemWidth'(1);
      state_o.cur_len   = LenWidth'(2);
    end else if (byte_i < LeadFour) begin
      state_o.partial   = CpWidth'(byte_i & MaskThree);
      state_o.remaining = RemWidth'(2);
      state_o.cur_len   = LenWidth'(3);
    end else if (byte_i < LeadBad) begin
      state_o.partial   = CpWidth'(byte_i & MaskFour);
      state_o.remaining = RemWidth'(3);
      state_o.cur_len   = LenWidth'(4);
    end else begin
      state_o.cur_len  = LenWidth'(1);
      res_valid_o      = 1'b1;
      res_o.code_point = CpReplacement;
      res_o.bad_lead   = 1'b1;
      count_o          = count_inc;
    end
  end

endmodule

@@ hdl/utf8_stream_decoder_core.sv @@
`timescale 1ns / 1ps
// utf8_stream_decoder_core: one byte per cycle utf-8 decoder with code point count
// depends on u8d_pkg, u8d_in_if, u8d_out_if, u8d_decode
// a taken byte is held in the input register, and its result is written to the output register when that byte advances
// throughput: one byte per cycle, set by the single decode step between input and result registers
// a result waiting in the output register stalls the input only once the held byte has a result too
// reset (asynchronous, active low) clears sequence state, the count and both valid flags

module utf8_stream_decoder_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  u8d_in_if.sink       in_i,
  u8d_out_if.source    out_o
);
  import u8d_pkg::*;

  logic                   in_valid_q;
  logic [7:0]             in_byte_q;
  seq_state_t             state_q, state_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   res_valid;
  char_res_t              res;
  logic [COUNT_WIDTH-1:0] res_count;
  logic                   out_valid_q;
  char_res_t              out_res_q;
  logic [COUNT_WIDTH-1:0] out_count_q;
  logic                   advance;

  u8d_decode #(.COUNT_WIDTH(COUNT_WIDTH)) u_decode (
    .byte_i      (in_byte_q),
    .state_i     (state_q),
    .count_i     (count_q),
    .state_o     (state_d),
    .count_o     (count_d),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_count_o (res_count)
  );

  // held byte moves on unless it makes a result and the output slot is full and not being read
  assign advance    = in_valid_q && (!res_valid || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      count_q     <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        state_q <= state_d;
        count_q <= count_d;
      end
      if (advance && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.in_byte;
    end
    if (advance && res_valid) begin
      out_res_q   <= res;
      out_count_q <= res_count;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.code_point    = out_res_q.code_point;
  assign out_o.seq_length    = out_res_q.seq_length;
  assign out_o.script_class  = out_res_q.script_class;
  assign out_o.bad_lead      = out_res_q.bad_lead;
  assign out_o.end_of_string = out_res_q.end_of_string;
  assign out_o.char_count    = out_count_q;

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_i.ready)
    else $error("input register empty but request refused");

  a_eos_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.end_of_string) |->
      (out_res_q.code_point == '0 && out_res_q.seq_length == LenWidth'(1) &&
       !out_res_q.bad_lead))
    else $error("terminator result malformed");

  a_bad_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.bad_lead) |->
      (out_res_q.code_point == CpReplacement && out_res_q.script_class == CLS_COMMON))
    else $error("bad lead without replacement character");

  a_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_valid && res.end_of_string) |=> (count_q == '0))
    else $error("count not cleared after terminator");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> $stable(out_count_q) && out_valid_q)
    else $error("pending result overwritten");

endmodule
